// ----- rtl/core/rpo_pkg.sv -----
// Shared types and constants for the RGB pixel point operations unit.
package rpo_pkg;

	localparam int PIX_W      = 8;
	localparam int NUM_LANES  = 3;
	localparam int GAIN_W     = 16;
	localparam int PROD_W     = PIX_W + GAIN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CHAN_W     = 2;
	localparam int MODE_W     = 3;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

	// Mean of three bytes: sum times 683, shift right by 11; exact for sums below 2048.
	localparam int SUM_W       = PIX_W + 2;
	localparam int DIV3_MUL_W  = 10;
	localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 10'd683;
	localparam int DIV3_SHIFT  = 11;
	localparam int MEAN_PROD_W = DIV3_SHIFT + PIX_W;

	// Reset values of the configuration registers
	localparam logic [MODE_W-1:0]  MODE_RST          = 3'd0;
	localparam logic [CHAN_W-1:0]  TINT_CHANNEL_RST  = 2'd0;
	localparam logic [GAIN_W-1:0]  REDUCE_GAIN_RST   = 16'd128;
	localparam logic [GAIN_W-1:0]  INCREASE_GAIN_RST = 16'd384;
	localparam logic [GAIN_W-1:0]  TINT_GAIN_RST     = 16'd320;
	localparam logic [PIX_W-1:0]   MONO_THRESH_RST   = 8'd127;

	typedef enum logic [MODE_W-1:0] {
		MODE_NEGATIVE  = 3'd0,
		MODE_GRAYSCALE = 3'd1,
		MODE_REDUCE    = 3'd2,
		MODE_INCREASE  = 3'd3,
		MODE_TINT      = 3'd4,
		MODE_MONO      = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE          = 3'd0,
		CFG_TINT_CHANNEL  = 3'd1,
		CFG_REDUCE_GAIN   = 3'd2,
		CFG_INCREASE_GAIN = 3'd3,
		CFG_TINT_GAIN     = 3'd4,
		CFG_MONO_THRESH   = 3'd5
	} cfg_idx_t;

	// What one lane hands to the merge stage
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [PIX_W-1:0] scaled;
	} lane_res_t;

endpackage

// ----- rtl/core/rpo_lane.sv -----
// One byte lane: registered gain multiply, then truncate and saturate.
module rpo_lane
	import rpo_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              en,
	input  logic [PIX_W-1:0]  pix,
	input  logic [GAIN_W-1:0] gain,
	output lane_res_t         res
);

	logic [PROD_W-1:0] prod_s2;
	logic [PIX_W-1:0]  pix_s2;
	logic [PROD_W-1:0] shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(pix) * PROD_W'(gain);
			pix_s2  <= pix;
		end
	end

	assign shifted    = prod_s2 >> GAIN_FRAC_BITS;
	assign res.pix    = pix_s2;
	assign res.scaled = (|shifted[PROD_W-1:PIX_W]) ? PIX_MAX : shifted[PIX_W-1:0];

endmodule

// ----- rtl/core/rpo_mean.sv -----
// Truncated mean of the three bytes by reciprocal multiplication.
module rpo_mean
	import rpo_pkg::*;
(
	input  logic                            clk,
	input  logic                            en,
	input  logic [NUM_LANES-1:0][PIX_W-1:0] pix,
	output logic [PIX_W-1:0]                mean
);

	logic [SUM_W-1:0]       sum;
	logic [MEAN_PROD_W-1:0] prod_s2;

	assign sum = SUM_W'(pix[0]) + SUM_W'(pix[1]) + SUM_W'(pix[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= MEAN_PROD_W'(sum) * MEAN_PROD_W'(DIV3_MUL);
		end
	end

	assign mean = prod_s2[MEAN_PROD_W-1:DIV3_SHIFT];

endmodule

// ----- rtl/core/rpo_merge.sv -----
// Merge stage: picks each output byte from the lane results and the mean.
module rpo_merge
	import rpo_pkg::*;
(
	input  logic [MODE_W-1:0]               mode,
	input  logic [CHAN_W-1:0]               tint_channel,
	input  logic [PIX_W-1:0]                mono_threshold,
	input  lane_res_t [NUM_LANES-1:0]       lane_res,
	input  logic [PIX_W-1:0]                mean,
	output logic [NUM_LANES-1:0][PIX_W-1:0] pix_out
);

	logic [PIX_W-1:0] mono_pix;

	assign mono_pix = (mean <= mono_threshold) ? PIX_MIN : PIX_MAX;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			unique case (mode_t'(mode))
				MODE_NEGATIVE:  pix_out[i] = PIX_MAX - lane_res[i].pix;
				MODE_GRAYSCALE: pix_out[i] = mean;
				MODE_REDUCE,
				MODE_INCREASE:  pix_out[i] = lane_res[i].scaled;
				MODE_TINT: begin
					pix_out[i] = (tint_channel == CHAN_W'(i)) ? lane_res[i].scaled
					                                          : lane_res[i].pix;
				end
				MODE_MONO:      pix_out[i] = mono_pix;
				default:        pix_out[i] = lane_res[i].pix;
			endcase
		end
	end

endmodule

// ----- rtl/core/rgb_pixel_point_ops_unit.sv -----
// Top level of the RGB pixel point operations unit.
// One pixel per clock when the output is not stalled, through three register stages: an input
// register, a multiply stage (three byte lanes, each with its own 8x16 gain multiplier, plus
// the mean unit's reciprocal multiply) and the output register fed by the merge stage. A
// result passes the input, multiply and output registers in that order before its output
// transfer. Each stage advances when the one after it is empty or moving, so a new pixel can
// be taken while a finished one still waits at the output. The mode register selects negative,
// grayscale, contrast reduce, contrast increase, tint (one channel) or monochrome; modes 6
// and 7, and tint on channel 3, pass the pixel through.
// Gains are unsigned with GAIN_FRAC_BITS fraction bits; scaled bytes truncate and saturate
// at 255. Write configuration only while no pixel is in flight.
module rgb_pixel_point_ops_unit
	import rpo_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // byte0 (blue), byte1 (green), byte2 (red)
	input  logic                  s_tlast,   // frame end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // byte0, byte1, byte2 transformed
	output logic                  m_tlast,   // frame end, copied through
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [CHAN_W-1:0] tint_channel_q;
	logic [GAIN_W-1:0] reduce_gain_q;
	logic [GAIN_W-1:0] increase_gain_q;
	logic [GAIN_W-1:0] tint_gain_q;
	logic [PIX_W-1:0]  mono_threshold_q;

	// Pipeline control and data
	logic                            v_s1, v_s2, out_valid_q;
	logic                            s1_en, s2_en, out_en;
	logic [NUM_LANES-1:0][PIX_W-1:0] pix_s1;
	logic                            last_s1, last_s2;
	logic [GAIN_W-1:0]               lane_gain;
	lane_res_t [NUM_LANES-1:0]       lane_res;
	logic [PIX_W-1:0]                mean;
	logic [NUM_LANES-1:0][PIX_W-1:0] merged;
	logic [23:0]                     m_tdata_q;
	logic                            m_tlast_q;

	// Writes are always taken; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_RST;
			tint_channel_q   <= TINT_CHANNEL_RST;
			reduce_gain_q    <= REDUCE_GAIN_RST;
			increase_gain_q  <= INCREASE_GAIN_RST;
			tint_gain_q      <= TINT_GAIN_RST;
			mono_threshold_q <= MONO_THRESH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:          mode_q           <= cfg_data[MODE_W-1:0];
				CFG_TINT_CHANNEL:  tint_channel_q   <= cfg_data[CHAN_W-1:0];
				CFG_REDUCE_GAIN:   reduce_gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_INCREASE_GAIN: increase_gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_TINT_GAIN:     tint_gain_q      <= cfg_data[GAIN_W-1:0];
				CFG_MONO_THRESH:   mono_threshold_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when the next one is empty or moving on
	assign out_en   = !out_valid_q || m_tready;
	assign s2_en    = !v_s2 || out_en;
	assign s1_en    = !v_s1 || s2_en;
	assign s_tready = s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en)  v_s1        <= s_tvalid;
			if (s2_en)  v_s2        <= v_s1;
			if (out_en) out_valid_q <= v_s2;
		end
	end

	// Input register: hold the pixel and its frame end flag
	always_ff @(posedge clk) begin
		if (s1_en) begin
			pix_s1[0] <= s_tdata[7:0];
			pix_s1[1] <= s_tdata[15:8];
			pix_s1[2] <= s_tdata[23:16];
			last_s1   <= s_tlast;
		end
		if (s2_en) begin
			last_s2 <= last_s1;
		end
	end

	// One gain serves all lanes; the merge stage decides which lanes use it.
	always_comb begin
		unique case (mode_t'(mode_q))
			MODE_REDUCE:   lane_gain = reduce_gain_q;
			MODE_INCREASE: lane_gain = increase_gain_q;
			default:       lane_gain = tint_gain_q;
		endcase
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rpo_lane #(
			.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.en   (s2_en),
			.pix  (pix_s1[i]),
			.gain (lane_gain),
			.res  (lane_res[i])
		);
	end

	rpo_mean u_mean (
		.clk  (clk),
		.en   (s2_en),
		.pix  (pix_s1),
		.mean (mean)
	);

	rpo_merge u_merge (
		.mode           (mode_q),
		.tint_channel   (tint_channel_q),
		.mono_threshold (mono_threshold_q),
		.lane_res       (lane_res),
		.mean           (mean),
		.pix_out        (merged)
	);

	// Output register: hold the result until the downstream transfer
	always_ff @(posedge clk) begin
		if (out_en) begin
			m_tdata_q <= {merged[2], merged[1], merged[0]};
			m_tlast_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- sim/tb_rgb_pixel_point_ops_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RGB pixel point operations unit, with a built-in predictor.
module tb_rgb_pixel_point_ops_unit;
	import rpo_pkg::*;

	localparam int GAIN_FRAC    = 8;
	localparam int PIPE_DEPTH   = 4;      // drain allowance, one more than the three pipeline stages
	localparam int HOLD_CYCLES  = 64;     // long output hold-off for the back-pressure test
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 125;

	// Codes the package enums leave unnamed
	localparam logic [MODE_W-1:0]    MODE_PASS_LO = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_PASS_HI = 3'd7;
	localparam logic [CHAN_W-1:0]    CH_BLUE      = 2'd0;
	localparam logic [CHAN_W-1:0]    CH_GREEN     = 2'd1;
	localparam logic [CHAN_W-1:0]    CH_RED       = 2'd2;
	localparam logic [CHAN_W-1:0]    CH_NONE      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [GAIN_W-1:0]    GAIN_ZERO    = 16'h0000;
	localparam logic [GAIN_W-1:0]    GAIN_FULL    = 16'hFFFF;
	localparam logic [GAIN_W-1:0]    GAIN_UNITY   = 16'h0001 << GAIN_FRAC;

	// One pixel as it travels on the stream: lane 0 (blue) in the lowest bits
	typedef struct packed {
		logic                               frame_end;
		logic [NUM_LANES-1:0][PIX_W-1:0]    lanes;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;   // byte0 (blue), byte1 (green), byte2 (red)
	logic                  s_tlast;   // frame end
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // byte0, byte1, byte2 transformed
	logic                  m_tlast;   // frame end
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the configuration registers
	logic [MODE_W-1:0] op_mode       = MODE_RST;
	logic [CHAN_W-1:0] tint_sel      = TINT_CHANNEL_RST;
	logic [GAIN_W-1:0] gain_reduce   = REDUCE_GAIN_RST;
	logic [GAIN_W-1:0] gain_increase = INCREASE_GAIN_RST;
	logic [GAIN_W-1:0] gain_tint     = TINT_GAIN_RST;
	logic [PIX_W-1:0]  mono_thresh   = MONO_THRESH_RST;

	pixel_t pending_pixels[$];   // predicted output pixels, oldest first
	int     mismatch_count = 0;
	int     cycle_count    = 0;
	bit     idle_on        = 1'b0;
	bit     stall_request  = 1'b0;
	bit     stall_taken    = 1'b0;

	rgb_pixel_point_ops_unit #(
		.GAIN_FRAC_BITS(GAIN_FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: fail and end the run when the cycle counter reaches CYCLE_LIMIT
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Multiply, drop the fraction bits and clamp at full scale
	function automatic logic [PIX_W-1:0] scaled_byte(logic [PIX_W-1:0] b, logic [GAIN_W-1:0] g);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(b) * PROD_W'(g);
		prod = prod >> GAIN_FRAC;
		return (prod > PIX_MAX) ? PIX_MAX : prod[PIX_W-1:0];
	endfunction

	// Predicted output pixel for one input pixel under the current settings
	function automatic pixel_t point_op_result(pixel_t px);
		pixel_t           res;
		logic [SUM_W-1:0] sum;
		logic [PIX_W-1:0] mean;
		res  = px;
		sum  = SUM_W'(px.lanes[0]) + SUM_W'(px.lanes[1]) + SUM_W'(px.lanes[2]);
		mean = PIX_W'(sum / NUM_LANES);
		case (op_mode)
			MODE_NEGATIVE:  for (int i = 0; i < NUM_LANES; i++) res.lanes[i] = PIX_MAX - px.lanes[i];
			MODE_GRAYSCALE: for (int i = 0; i < NUM_LANES; i++) res.lanes[i] = mean;
			MODE_REDUCE:    for (int i = 0; i < NUM_LANES; i++)
				res.lanes[i] = scaled_byte(px.lanes[i], gain_reduce);
			MODE_INCREASE:  for (int i = 0; i < NUM_LANES; i++)
				res.lanes[i] = scaled_byte(px.lanes[i], gain_increase);
			MODE_TINT: begin
				// channel 3 selects no lane, so the pixel passes through
				if (tint_sel != CH_NONE)
					res.lanes[tint_sel] = scaled_byte(px.lanes[tint_sel], gain_tint);
			end
			MODE_MONO: for (int i = 0; i < NUM_LANES; i++)
				res.lanes[i] = (mean <= mono_thresh) ? PIX_MIN : PIX_MAX;
			default: ;  // unused modes pass the pixel through
		endcase
		return res;
	endfunction

	// Lane values lean towards the extremes so saturation and clamping get hit often
	function automatic pixel_t random_pixel();
		pixel_t px;
		for (int i = 0; i < NUM_LANES; i++) begin
			case ($urandom_range(0, 7))
				0:       px.lanes[i] = PIX_MIN;
				1:       px.lanes[i] = PIX_MAX;
				default: px.lanes[i] = PIX_W'($urandom);
			endcase
		end
		px.frame_end = ($urandom_range(0, 15) == 0);
		return px;
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 4))
			0:       return GAIN_ZERO;
			1:       return GAIN_FULL;
			2:       return GAIN_UNITY;
			3:       return GAIN_W'($urandom_range(0, 1023));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Offer one pixel, starting at a falling edge; return at the falling edge after the transfer
	task automatic send_pixel(input pixel_t px);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = px.lanes;
		s_tlast  = px.frame_end;
		do @(posedge clk); while (!s_tready);
		pending_pixels.push_back(point_op_result(px));
		@(negedge clk);
	endtask

	// Stop offering, let every expected pixel out, then allow the pipeline to settle
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MODE:          op_mode       = value[MODE_W-1:0];
			CFG_TINT_CHANNEL:  tint_sel      = value[CHAN_W-1:0];
			CFG_REDUCE_GAIN:   gain_reduce   = value[GAIN_W-1:0];
			CFG_INCREASE_GAIN: gain_increase = value[GAIN_W-1:0];
			CFG_TINT_GAIN:     gain_tint     = value[GAIN_W-1:0];
			CFG_MONO_THRESH:   mono_thresh   = value[PIX_W-1:0];
			default: ;  // spare indexes hold nothing
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Output side: random ready bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request && !stall_taken) begin
				stall_taken = 1'b1;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	// Compare every output transfer with the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		pixel_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tdata};
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected output transfer, expected none, actual %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				for (int i = 0; i < NUM_LANES; i++) begin
					if (got.lanes[i] !== want.lanes[i]) begin
						$display("%0t: byte%0d expected %02h actual %02h (mode %0d)",
							$time, i, want.lanes[i], got.lanes[i], op_mode);
						mismatch_count++;
					end
				end
				if (got.frame_end !== want.frame_end) begin
					$display("%0t: frame end expected %b actual %b",
						$time, want.frame_end, got.frame_end);
					mismatch_count++;
				end
			end
		end
	end

	// Reset values: negative mode, then each mode on its default gain and threshold
	task automatic test_reset_values();
		send_pixel({1'b0, PIX_MIN, PIX_MIN, PIX_MIN});
		send_pixel({1'b1, PIX_MAX, PIX_MAX, PIX_MAX});
		send_pixel({1'b0, 8'hFE, 8'h80, 8'h01});
		set_reg(CFG_MODE, MODE_GRAYSCALE);
		send_pixel({1'b0, PIX_MAX, PIX_MAX, PIX_MAX});
		send_pixel({1'b1, 8'h01, 8'h02, 8'h02});
		set_reg(CFG_MODE, MODE_REDUCE);
		send_pixel({1'b0, 8'h01, 8'h80, PIX_MAX});
		set_reg(CFG_MODE, MODE_INCREASE);
		send_pixel({1'b0, 8'h55, 8'hAA, PIX_MAX});
		set_reg(CFG_MODE, MODE_TINT);
		send_pixel({1'b0, 8'h40, 8'h40, PIX_MAX});
		set_reg(CFG_MODE, MODE_MONO);
		// mean exactly on the threshold twice, then one above it
		send_pixel({1'b0, 8'h7F, 8'h7F, 8'h7F});
		send_pixel({1'b0, 8'h7F, 8'h80, 8'h80});
		send_pixel({1'b1, 8'h80, 8'h80, 8'h80});
	endtask

	// Gain and threshold extremes, tint on green, red and channel 3, and the unused modes
	task automatic test_extremes();
		set_reg(CFG_MODE, MODE_REDUCE);
		set_reg(CFG_REDUCE_GAIN, GAIN_ZERO);
		send_pixel({1'b0, PIX_MAX, PIX_MAX, PIX_MAX});
		set_reg(CFG_REDUCE_GAIN, GAIN_FULL);
		send_pixel({1'b0, PIX_MAX, PIX_MIN, 8'h01});
		set_reg(CFG_MODE, MODE_INCREASE);
		set_reg(CFG_INCREASE_GAIN, GAIN_UNITY);
		send_pixel({1'b0, 8'h56, 8'h34, 8'h12});
		set_reg(CFG_MODE, MODE_TINT);
		set_reg(CFG_TINT_GAIN, GAIN_FULL);
		set_reg(CFG_TINT_CHANNEL, CH_GREEN);
		send_pixel({1'b0, 8'h03, 8'h02, 8'h01});
		set_reg(CFG_TINT_CHANNEL, CH_RED);
		send_pixel({1'b0, 8'h03, 8'h02, 8'h01});
		set_reg(CFG_TINT_CHANNEL, CH_NONE);
		send_pixel({1'b0, 8'h03, 8'h02, 8'h01});
		set_reg(CFG_MODE, MODE_MONO);
		set_reg(CFG_MONO_THRESH, PIX_MIN);
		send_pixel({1'b0, 8'h02, PIX_MIN, PIX_MIN});
		send_pixel({1'b0, 8'h01, 8'h01, 8'h01});
		set_reg(CFG_MONO_THRESH, PIX_MAX);
		send_pixel({1'b1, PIX_MAX, PIX_MAX, PIX_MAX});
		set_reg(CFG_MODE, MODE_PASS_LO);
		send_pixel({1'b0, 8'hC3, 8'h5A, 8'h0F});
		set_reg(CFG_MODE, MODE_PASS_HI);
		send_pixel({1'b1, 8'h0F, 8'hA5, 8'hF0});
		// spare register indexes must change nothing
		set_reg(CFG_SPARE_LO, GAIN_FULL);
		set_reg(CFG_SPARE_HI, GAIN_ZERO);
		send_pixel({1'b0, 8'h11, 8'h22, 8'h33});
	endtask

	// One phase per mode code, other registers random, upper data bits on the narrow ones noisy
	task automatic test_random_settings();
		logic [MODE_W-1:0] phase_modes[8];
		phase_modes = '{MODE_NEGATIVE, MODE_GRAYSCALE, MODE_REDUCE, MODE_INCREASE,
			MODE_TINT, MODE_MONO, MODE_PASS_LO, MODE_PASS_HI};
		phase_modes.shuffle();
		for (int p = 0; p < 8; p++) begin
			set_reg(CFG_MODE, {(CFG_DATA_W-MODE_W)'($urandom), phase_modes[p]});
			set_reg(CFG_TINT_CHANNEL, {(CFG_DATA_W-CHAN_W)'($urandom), CHAN_W'($urandom)});
			set_reg(CFG_REDUCE_GAIN, random_gain());
			set_reg(CFG_INCREASE_GAIN, random_gain());
			set_reg(CFG_TINT_GAIN, random_gain());
			set_reg(CFG_MONO_THRESH, {(CFG_DATA_W-PIX_W)'($urandom),
				($urandom_range(0, 3) == 0) ? PIX_MAX : PIX_W'($urandom)});
			// some phases run with no gaps at all
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (PHASE_ITEMS) send_pixel(random_pixel());
		end
		idle_on = 1'b1;
	endtask

	// Hold the output off long enough for the pipeline to fill and block the input
	task automatic test_backpressure();
		set_reg(CFG_MODE, MODE_TINT);
		set_reg(CFG_TINT_CHANNEL, CH_BLUE);
		stall_request = 1'b1;
		repeat (40) send_pixel(random_pixel());
	endtask

	// Back-to-back transfers on both sides
	task automatic test_full_rate();
		set_reg(CFG_MODE, MODE_INCREASE);
		idle_on = 1'b0;
		repeat (100) send_pixel(random_pixel());
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		idle_on = 1'b1;
		test_extremes();
		test_random_settings();
		test_backpressure();
		test_full_rate();

		wait_idle();
		repeat (2 * PIPE_DEPTH) @(negedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
